// ----- design/facing_direction_16way_macros.svh -----
// ----------------------------------------------------------------------------
// facing_direction_16way assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef FACING_DIRECTION_16WAY_MACROS_SVH
`define FACING_DIRECTION_16WAY_MACROS_SVH

// same-cycle implication, off during reset
`define FD16_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fd16 check failed");

// next-cycle implication, off during reset
`define FD16_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fd16 check failed");

// next-cycle implication, active during reset
`define FD16_ASSERT_NEXT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fd16 reset check failed");

`endif

// ----- design/fd16_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fd16_pkg
// widths, stage counts and the direction grid for facing_direction_16way
// ----------------------------------------------------------------------------
package fd16_pkg;

  localparam int CW    = 16;           // coordinate width
  localparam int SQW   = CW + 1;       // root width
  localparam int RW    = 2 * SQW;      // padded radicand width
  localparam int RMW   = SQW + 3;      // partial remainder width
  localparam int NS    = SQW + 4;      // register stages
  localparam int GRID  = 5;
  localparam int NEAR_LIMIT = 3;

  localparam logic [2:0] GRID_MID = 3'd2;

  localparam logic [3:0] DIR_TABLE [GRID][GRID] = '{
    '{4'd6, 4'd7, 4'd8, 4'd9,  4'd10},
    '{4'd5, 4'd6, 4'd8, 4'd10, 4'd11},
    '{4'd4, 4'd4, 4'd0, 4'd12, 4'd12},
    '{4'd3, 4'd2, 4'd0, 4'd14, 4'd13},
    '{4'd2, 4'd1, 4'd0, 4'd15, 4'd14}
  };

  typedef struct packed {
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    logic          nx;
    logic          ny;
  } geo_t;

endpackage

// ----- design/fd16_query_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fd16_query_if
// point pair channel: source and destination coordinates
// ----------------------------------------------------------------------------
interface fd16_query_if;

  logic                           valid;
  logic                           ready;
  logic signed [fd16_pkg::CW-1:0] src_x;
  logic signed [fd16_pkg::CW-1:0] src_y;
  logic signed [fd16_pkg::CW-1:0] dst_x;
  logic signed [fd16_pkg::CW-1:0] dst_y;

  modport source (output valid, output src_x, output src_y, output dst_x,
                  output dst_y, input ready);
  modport sink (input valid, input src_x, input src_y, input dst_x,
                input dst_y, output ready);

endinterface

// ----- design/fd16_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fd16_result_if
// facing direction channel
// ----------------------------------------------------------------------------
interface fd16_result_if;

  logic       valid;
  logic       ready;
  logic [3:0] facing;

  modport source (output valid, output facing, input ready);
  modport sink (input valid, input facing, output ready);

endinterface

// ----- design/facing_direction_16way.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// facing_direction_16way
// 16-way facing direction from a source point toward a destination point
// ----------------------------------------------------------------------------
// query carries src_x, src_y, dst_x, dst_y; result carries facing (0..15).
// Both are valid/ready channels; a word moves when valid and ready are high.
// The distance is an exact integer square root of dx*dx + dy*dy, one root
// bit per register stage, followed by a compare stage that picks the grid
// cell. The pipeline holds 21 stages: abs difference, squares, sum, 17 root
// stages and the output register. With no stall, one query is taken every cycle.
// Every stage keeps a valid bit; a stage loads whenever it is empty or the
// stage after it moves, so bubbles close up and a stalled result register
// still lets the earlier stages fill. While the receiver holds ready low the
// result word and facing stay put; up to 21 words sit in flight.
// Synchronous reset empties all stages; payload registers are not cleared.
// ----------------------------------------------------------------------------
module facing_direction_16way (
  input  logic          clk,
  input  logic          rst,
  fd16_query_if.sink    query,
  fd16_result_if.source result
);

  localparam int CW   = fd16_pkg::CW;
  localparam int SQW  = fd16_pkg::SQW;
  localparam int RW   = fd16_pkg::RW;
  localparam int RMW  = fd16_pkg::RMW;
  localparam int NS   = fd16_pkg::NS;

  logic [NS-1:0]      v;
  logic [NS-1:0]      rdy;

  fd16_pkg::geo_t     geo  [NS-1];
  logic [2*CW-1:0]    sq_x;
  logic [2*CW-1:0]    sq_y;
  logic [RW-1:0]      rad  [SQW+1];
  logic [RMW-1:0]     rem  [SQW+1];
  logic [SQW-1:0]     root [SQW+1];
  logic [3:0]         facing;

  // stage handshake
  assign rdy[NS-1] = !v[NS-1] || result.ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= query.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 0: absolute differences
  logic [CW:0] dx;
  logic [CW:0] dy;
  logic [CW:0] dx_neg;
  logic [CW:0] dy_neg;

  always_comb begin
    dx     = {query.src_x[CW-1], query.src_x} - {query.dst_x[CW-1], query.dst_x};
    dy     = {query.src_y[CW-1], query.src_y} - {query.dst_y[CW-1], query.dst_y};
    dx_neg = -dx;
    dy_neg = -dy;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      geo[0].nx <= dx[CW];
      geo[0].ny <= dy[CW];
      geo[0].ax <= dx[CW] ? dx_neg[CW-1:0] : dx[CW-1:0];
      geo[0].ay <= dy[CW] ? dy_neg[CW-1:0] : dy[CW-1:0];
    end
  end

  // stage 1: squares
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      geo[1] <= geo[0];
      sq_x   <= geo[0].ax * geo[0].ax;
      sq_y   <= geo[0].ay * geo[0].ay;
    end
  end

  // stage 2: sum of squares
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      geo[2]  <= geo[1];
      rad[0]  <= RW'({1'b0, sq_x} + {1'b0, sq_y});
      rem[0]  <= '0;
      root[0] <= '0;
    end
  end

  // root stages, one bit each
  for (genvar j = 1; j <= SQW; j++) begin : g_root
    logic [RMW-1:0] rsh;
    logic [RMW-1:0] trial;
    logic           take;

    always_comb begin
      rsh   = {rem[j-1][RMW-3:0], rad[j-1][RW-1:RW-2]};
      trial = {1'b0, root[j-1], 2'b01};
      take  = rsh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rdy[j+2]) begin
        geo[j+2] <= geo[j+1];
        rad[j]   <= {rad[j-1][RW-3:0], 2'b00};
        rem[j]   <= take ? (rsh - trial) : rsh;
        root[j]  <= {root[j-1][SQW-2:0], take};
      end
    end
  end

  // final stage: quotient compares and grid lookup
  fd16_pkg::geo_t  gf;
  logic [SQW-1:0]  d;
  logic [SQW-1:0]  dh;
  logic [SQW:0]    axe;
  logic [SQW:0]    aye;
  logic [1:0]      qx;
  logic [1:0]      qy;
  logic [2:0]      col;
  logic [2:0]      row;
  logic [3:0]      facing_next;

  always_comb begin
    gf  = geo[NS-2];
    d   = root[SQW];
    dh  = (d > SQW'(fd16_pkg::NEAR_LIMIT)) ? (d >> 1) : d;
    axe = (SQW+1)'(gf.ax);
    aye = (SQW+1)'(gf.ay);
    if (axe >= {dh, 1'b0}) begin
      qx = 2'd2;
    end else if (axe >= {1'b0, dh}) begin
      qx = 2'd1;
    end else begin
      qx = 2'd0;
    end
    if (aye >= {dh, 1'b0}) begin
      qy = 2'd2;
    end else if (aye >= {1'b0, dh}) begin
      qy = 2'd1;
    end else begin
      qy = 2'd0;
    end
    col = gf.nx ? (fd16_pkg::GRID_MID - {1'b0, qx}) : (fd16_pkg::GRID_MID + {1'b0, qx});
    row = gf.ny ? (fd16_pkg::GRID_MID - {1'b0, qy}) : (fd16_pkg::GRID_MID + {1'b0, qy});
    facing_next = (d == '0) ? 4'd0 : fd16_pkg::DIR_TABLE[row][col];
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      facing <= facing_next;
    end
  end

  assign query.ready   = rdy[0];
  assign result.valid  = v[NS-1];
  assign result.facing = facing;

endmodule

// ----- design/fd16_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fd16_checker
// port-level checks for facing_direction_16way, attached by bind
// ----------------------------------------------------------------------------
`include "facing_direction_16way_macros.svh"

module fd16_checker (
  input logic clk,
  input logic rst,
  input logic q_ready,
  input logic r_valid,
  input logic r_ready
);

  // a waiting result word is not dropped
  `FD16_ASSERT_NEXT(a_hold_valid, r_valid && !r_ready, r_valid)

  // reset empties the pipeline
  `FD16_ASSERT_NEXT_RST(a_reset_empty, rst, !r_valid)

  // a free receiver means the whole pipeline moves
  `FD16_ASSERT_NOW(a_flow_through, r_ready, q_ready)

endmodule

bind facing_direction_16way fd16_checker u_fd16_checker (
  .clk     (clk),
  .rst     (rst),
  .q_ready (query.ready),
  .r_valid (result.valid),
  .r_ready (result.ready)
);

// ----- bench/tb_facing_direction_16way.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_facing_direction_16way
// checks the 16-way facing direction against a bit-exact predictor: directed
// corner and near-distance pairs, then random pairs under three idle
// patterns and a long result stall that backs the pipeline up to its input
// ----------------------------------------------------------------------------
module tb_facing_direction_16way;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  localparam logic [3:0] FACING_GRID [5][5] = '{
    '{4'd6, 4'd7, 4'd8, 4'd9,  4'd10},
    '{4'd5, 4'd6, 4'd8, 4'd10, 4'd11},
    '{4'd4, 4'd4, 4'd0, 4'd12, 4'd12},
    '{4'd3, 4'd2, 4'd0, 4'd14, 4'd13},
    '{4'd2, 4'd1, 4'd0, 4'd15, 4'd14}
  };

  logic clk;
  logic rst;

  fd16_query_if  query_bus ();
  fd16_result_if result_bus ();

  facing_direction_16way uut (
    .clk    (clk),
    .rst    (rst),
    .query  (query_bus),
    .result (result_bus)
  );

  logic [3:0] expected_facing [$];
  int         mismatches;
  int         cycle_count;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         hold_token;
  int         hold_seen;
  int         hold_left;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // truncated quotient magnitude, clamped to the grid radius
  function automatic int grid_step(logic [16:0] mag, logic [17:0] span, logic neg);
    logic [17:0] q;
    int          s;
    q = 18'(mag) / span;
    s = (q > 18'd2) ? 2 : int'(q);
    return neg ? -s : s;
  endfunction

  function automatic logic [3:0] facing_of(logic signed [15:0] sx, logic signed [15:0] sy,
                                           logic signed [15:0] tx, logic signed [15:0] ty);
    logic [16:0] dx;
    logic [16:0] dy;
    logic [16:0] ax;
    logic [16:0] ay;
    logic [35:0] rsq;
    logic [35:0] sq;
    logic [17:0] root;
    logic [17:0] trial;
    logic [17:0] span;
    int          qx;
    int          qy;
    dx = {sx[15], sx} - {tx[15], tx};
    dy = {sy[15], sy} - {ty[15], ty};
    ax = dx[16] ? (~dx + 17'd1) : dx;
    ay = dy[16] ? (~dy + 17'd1) : dy;
    rsq = 36'(ax) * 36'(ax) + 36'(ay) * 36'(ay);
    root = '0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (18'd1 << b);
      sq = 36'(trial) * 36'(trial);
      if (sq <= rsq) root = trial;
    end
    if (root == '0) return 4'd0;
    span = (root > 18'd3) ? (root >> 1) : root;
    qx = grid_step(ax, span, dx[16]);
    qy = grid_step(ay, span, dy[16]);
    return FACING_GRID[qy + 2][qx + 2];
  endfunction

  task automatic send_pair(logic signed [15:0] sx, logic signed [15:0] sy,
                           logic signed [15:0] tx, logic signed [15:0] ty);
    if ($urandom_range(99) < send_idle_pct) begin
      query_bus.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    query_bus.valid <= 1'b1;
    query_bus.src_x <= sx;
    query_bus.src_y <= sy;
    query_bus.dst_x <= tx;
    query_bus.dst_y <= ty;
    @(posedge clk);
    while (!query_bus.ready) @(posedge clk);
    expected_facing.push_back(facing_of(sx, sy, tx, ty));
  endtask

  task automatic send_random_pair();
    logic signed [15:0] corner [5];
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    int                 kind;
    int                 ox;
    int                 oy;
    corner = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    kind = $urandom_range(99);
    sx = 16'($urandom);
    sy = 16'($urandom);
    tx = 16'($urandom);
    ty = 16'($urandom);
    if (kind < 25) begin
      // near points, distance a few units
      ox = $urandom_range(16) - 8;
      oy = $urandom_range(16) - 8;
      tx = sx + 16'(ox);
      ty = sy + 16'(oy);
    end else if (kind < 45) begin
      ox = $urandom_range(4000) - 2000;
      oy = $urandom_range(4000) - 2000;
      tx = sx + 16'(ox);
      ty = sy + 16'(oy);
    end else if (kind < 55) begin
      // on an axis or a diagonal
      ox = $urandom_range(2000) - 1000;
      case ($urandom_range(3))
        0: begin
          tx = sx + 16'(ox);
          ty = sy;
        end
        1: begin
          tx = sx;
          ty = sy + 16'(ox);
        end
        2: begin
          tx = sx + 16'(ox);
          ty = sy + 16'(ox);
        end
        default: begin
          tx = sx + 16'(ox);
          ty = sy - 16'(ox);
        end
      endcase
    end else if (kind < 65) begin
      sx = corner[$urandom_range(4)];
      sy = corner[$urandom_range(4)];
      tx = corner[$urandom_range(4)];
      ty = corner[$urandom_range(4)];
    end
    send_pair(sx, sy, tx, ty);
  endtask

  task automatic test_corners_and_near_points();
    // coinciding points
    send_pair(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_pair(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_pair(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    // widest spans
    send_pair(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
    send_pair(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    send_pair(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    send_pair(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    send_pair(16'sd32767, 16'sd0, -16'sd32768, 16'sd0);
    send_pair(16'sd0, -16'sd32768, 16'sd0, 16'sd32767);
    // distance one to four, around the halving threshold
    send_pair(16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_pair(16'sd0, 16'sd1, 16'sd0, 16'sd0);
    send_pair(-16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_pair(16'sd0, -16'sd1, 16'sd0, 16'sd0);
    send_pair(16'sd1, 16'sd1, 16'sd0, 16'sd0);
    send_pair(16'sd2, 16'sd0, 16'sd0, 16'sd0);
    send_pair(16'sd3, 16'sd0, 16'sd0, 16'sd0);
    send_pair(16'sd4, 16'sd0, 16'sd0, 16'sd0);
    send_pair(16'sd2, 16'sd3, 16'sd0, 16'sd0);
    send_pair(16'sd3, 16'sd3, 16'sd0, 16'sd0);
    // off-axis directions at a larger radius
    send_pair(16'sd1000, 16'sd400, 16'sd0, 16'sd0);
    send_pair(16'sd400, -16'sd1000, 16'sd0, 16'sd0);
    send_pair(-16'sd1000, 16'sd400, 16'sd0, 16'sd0);
    send_pair(-16'sd400, -16'sd1000, 16'sd0, 16'sd0);
    send_pair(-16'sd707, 16'sd707, 16'sd0, 16'sd0);
    send_pair(16'sd0, 16'sd0, 16'sd500, -16'sd500);
  endtask

  task automatic test_random_points(int count);
    repeat (count) send_random_pair();
  endtask

  task automatic test_stalled_output();
    send_idle_pct = 0;
    hold_token <= hold_token + 1;
    repeat (80) send_random_pair();
  endtask

  // result side: random ready, long hold on request, check each word
  always @(posedge clk) begin
    if (result_bus.valid && result_bus.ready) begin
      if (expected_facing.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: facing %0d", result_bus.facing);
      end else begin
        if (result_bus.facing !== expected_facing[0]) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("facing mismatch: expected %0d actual %0d",
                     expected_facing[0], result_bus.facing);
        end
        void'(expected_facing.pop_front());
      end
    end
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      result_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    query_bus.valid = 1'b0;
    query_bus.src_x = '0;
    query_bus.src_y = '0;
    query_bus.dst_x = '0;
    query_bus.dst_y = '0;
    result_bus.ready = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    hold_token = 0;
    hold_seen = 0;
    hold_left = 0;
    send_idle_pct = 29;
    recv_idle_pct = 52;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corners_and_near_points();
    test_random_points(600);
    test_stalled_output();
    send_idle_pct = 52;
    recv_idle_pct = 29;
    test_random_points(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_points(600);
    query_bus.valid <= 1'b0;

    while (expected_facing.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- facing_direction_16way.f -----
+incdir+design
design/fd16_pkg.sv
design/fd16_query_if.sv
design/fd16_result_if.sv
design/facing_direction_16way.sv
design/fd16_checker.sv
bench/tb_facing_direction_16way.sv
